[design/ufs_pkg.sv]
// Shared constants for the union-find set engine.
`default_nettype none

package ufs_pkg;

    localparam int         UFS_MAX_ELEMENTS  = 1024;
    localparam int         FIELD_W           = 11;
    localparam logic [10:0] FIELD_MAX        = 11'h7FF;
    localparam logic [10:0] NUM_ELEMENTS_RST = 11'd1024;

    // APB register map: one word-aligned register.
    localparam int         APB_AW            = 3;
    localparam logic       REG_NUM_ELEMENTS  = 1'b0;

    localparam logic       OP_UNITE          = 1'b1;

endpackage : ufs_pkg

`default_nettype wire

[design/union_find_sets_unit.sv]
// Union-find engine: union by size with full path compression, state held in two RAMs.
// Each item walks both indices to their roots, pointing every path node at its root; a merge
// then links the two roots by size. An index error goes straight to the result state.
// One item is in flight at a time; a held result stalls the engine in its last state.
// After reset the parent and size RAMs are initialized, one entry per cycle, for entries
// 0 to MAX_ELEMENTS; no input beat is taken until that pass ends.
`default_nettype none

module union_find_sets_unit
    import ufs_pkg::*;
#(
    parameter int MAX_ELEMENTS = UFS_MAX_ELEMENTS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_op,
    input  wire logic [FIELD_W-1:0]  i_first_index,
    input  wire logic [FIELD_W-1:0]  i_second_index,
    // output channel
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic      [FIELD_W-1:0]  o_first_root,
    output logic      [FIELD_W-1:0]  o_second_root,
    output logic                     o_in_same_set,
    output logic                     o_merged,
    output logic      [FIELD_W-1:0]  o_set_size,
    output logic                     o_index_error,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    localparam int DEPTH = MAX_ELEMENTS + 1;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_NEXTB = 3'd4;
    localparam logic [2:0] S_SZA   = 3'd5;
    localparam logic [2:0] S_SZB   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [AW-1:0]      r_a, n_a, r_b, n_b, r_cur, n_cur, r_root, n_root;
    logic [AW-1:0]      r_ra, n_ra, r_rb, n_rb, r_sa, n_sa, r_size, n_size;
    logic               r_op, n_op, r_phase, n_phase, r_err, n_err, r_merged, n_merged;
    logic [FIELD_W-1:0] r_num;

    logic               r_ov, n_ov;
    logic [FIELD_W-1:0] r_o_ra, n_o_ra, r_o_rb, n_o_rb, r_o_size, n_o_size;
    logic               r_o_same, n_o_same, r_o_merged, n_o_merged, r_o_err, n_o_err;

    logic               p_we, s_we;
    logic [AW-1:0]      p_waddr, p_wdata, p_raddr, p_rdata;
    logic [AW-1:0]      s_waddr, s_wdata, s_raddr, s_rdata;

    logic               w_err;
    logic [AW-1:0]      w_start;
    logic               w_cfg_wr;

    ufs_ram #(.DEPTH(DEPTH), .WIDTH(AW)) u_parent (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    ufs_ram #(.DEPTH(DEPTH), .WIDTH(AW)) u_size (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_ELEMENTS);
    assign prdata   = (paddr[2] == REG_NUM_ELEMENTS) ? 32'(r_num) : 32'd0;

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ov;
    assign o_first_root  = r_o_ra;
    assign o_second_root = r_o_rb;
    assign o_in_same_set = r_o_same;
    assign o_merged      = r_o_merged;
    assign o_set_size    = r_o_size;
    assign o_index_error = r_o_err;

    assign w_err = (i_first_index == '0) || (i_second_index == '0)
                || (i_first_index > r_num) || (i_second_index > r_num)
                || (32'(i_first_index) > 32'(MAX_ELEMENTS))
                || (32'(i_second_index) > 32'(MAX_ELEMENTS));

    assign w_start = r_phase ? r_b : r_a;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_a        = r_a;
        n_b        = r_b;
        n_cur      = r_cur;
        n_root     = r_root;
        n_ra       = r_ra;
        n_rb       = r_rb;
        n_sa       = r_sa;
        n_size     = r_size;
        n_op       = r_op;
        n_phase    = r_phase;
        n_err      = r_err;
        n_merged   = r_merged;
        n_ov       = r_ov && !i_ready;
        n_o_ra     = r_o_ra;
        n_o_rb     = r_o_rb;
        n_o_size   = r_o_size;
        n_o_same   = r_o_same;
        n_o_merged = r_o_merged;
        n_o_err    = r_o_err;

        p_we    = 1'b0;
        p_waddr = r_cur;
        p_wdata = r_root;
        p_raddr = r_cur;
        s_we    = 1'b0;
        s_waddr = r_ra;
        s_wdata = r_sa;
        s_raddr = r_ra;

        unique case (r_state)
            S_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = r_clr;
                p_wdata = r_clr;
                s_we    = 1'b1;
                s_waddr = r_clr;
                s_wdata = AW'(1);
                if (r_clr == AW'(MAX_ELEMENTS)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = i_op;
                    n_a      = AW'(i_first_index);
                    n_b      = AW'(i_second_index);
                    n_phase  = 1'b0;
                    n_err    = w_err;
                    n_merged = 1'b0;
                    if (w_err) begin
                        n_state = S_FIN;
                    end else begin
                        p_raddr = AW'(i_first_index);
                        n_cur   = AW'(i_first_index);
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // p_rdata is the parent of r_cur; a self link marks the root.
                if (p_rdata == r_cur) begin
                    n_root = r_cur;
                    if (r_phase) begin
                        n_rb = r_cur;
                    end else begin
                        n_ra = r_cur;
                    end
                    if (w_start != r_cur) begin
                        p_raddr = w_start;
                        n_cur   = w_start;
                        n_state = S_CMP;
                    end else if (!r_phase) begin
                        n_state = S_NEXTB;
                    end else begin
                        n_state = S_SZA;
                    end
                end else begin
                    p_raddr = p_rdata;
                    n_cur   = p_rdata;
                end
            end
            S_CMP: begin
                // Point r_cur at the root while fetching the next node's parent.
                p_we    = 1'b1;
                p_waddr = r_cur;
                p_wdata = r_root;
                if (p_rdata == r_root) begin
                    n_state = r_phase ? S_SZA : S_NEXTB;
                end else begin
                    p_raddr = p_rdata;
                    n_cur   = p_rdata;
                end
            end
            S_NEXTB: begin
                p_raddr = r_b;
                n_cur   = r_b;
                n_phase = 1'b1;
                n_state = S_WALK;
            end
            S_SZA: begin
                if ((r_op == OP_UNITE) && (r_ra != r_rb)) begin
                    n_sa    = s_rdata;
                    s_raddr = r_rb;
                    n_state = S_SZB;
                end else begin
                    n_size  = s_rdata;
                    n_state = S_FIN;
                end
            end
            S_SZB: begin
                // On equal sizes the first root stays the root.
                p_we    = 1'b1;
                s_we    = 1'b1;
                s_wdata = AW'(r_sa + s_rdata);
                if (r_sa < s_rdata) begin
                    p_waddr = r_ra;
                    p_wdata = r_rb;
                    s_waddr = r_rb;
                end else begin
                    p_waddr = r_rb;
                    p_wdata = r_ra;
                    s_waddr = r_ra;
                end
                n_size   = AW'(r_sa + s_rdata);
                n_merged = 1'b1;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || i_ready) begin
                    n_ov       = 1'b1;
                    n_o_err    = r_err;
                    n_o_ra     = r_err ? '0 : FIELD_W'(r_ra);
                    n_o_rb     = r_err ? '0 : FIELD_W'(r_rb);
                    n_o_same   = !r_err && (r_ra == r_rb);
                    n_o_merged = !r_err && r_merged;
                    if (r_err) begin
                        n_o_size = '0;
                    end else if (32'(r_size) > 32'(FIELD_MAX)) begin
                        n_o_size = FIELD_MAX;
                    end else begin
                        n_o_size = FIELD_W'(r_size);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_num   <= NUM_ELEMENTS_RST;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            if (w_cfg_wr) begin
                r_num <= pwdata[FIELD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_cur      <= n_cur;
        r_root     <= n_root;
        r_ra       <= n_ra;
        r_rb       <= n_rb;
        r_sa       <= n_sa;
        r_size     <= n_size;
        r_op       <= n_op;
        r_phase    <= n_phase;
        r_err      <= n_err;
        r_merged   <= n_merged;
        r_o_ra     <= n_o_ra;
        r_o_rb     <= n_o_rb;
        r_o_size   <= n_o_size;
        r_o_same   <= n_o_same;
        r_o_merged <= n_o_merged;
        r_o_err    <= n_o_err;
    end

endmodule : union_find_sets_unit

`default_nettype wire

[design/ufs_ram.sv]
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none

module ufs_ram
    import ufs_pkg::*;
#(
    parameter int DEPTH = UFS_MAX_ELEMENTS + 1,
    parameter int WIDTH = $clog2(UFS_MAX_ELEMENTS + 1),
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : ufs_ram

`default_nettype wire
